### src/erot_pkg.sv
// Shared types, widths and the quarter-wave sine table for the Euler point rotator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package erot_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned COORD_W         = 24;
  localparam int unsigned ANGLE_W         = 16;
  localparam int unsigned COEF_W          = 16;
  localparam int unsigned FRAC_W          = 15;
  localparam int unsigned PROD_W          = COEF_W + COORD_W;
  localparam int unsigned SUM_W           = PROD_W + 1;
  localparam int unsigned QUARTER_LEN     = 1 << SINE_TABLE_BITS;
  localparam int unsigned LUT_W           = 15;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          Q30_ONE     = 64'sd1 << 30;

  localparam logic [ANGLE_W-1:0] ANGLE_RESET = ANGLE_W'(10430);
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(16384);

  // APB register map, one word per register
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  typedef enum logic [1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } reg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_val_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    coef_val_t cos_v;
    coef_val_t sin_v;
  } coef_t;

  typedef logic [LUT_W-1:0] sine_lut_t [0:QUARTER_LEN];

  // Taylor series through x^15 in Q30, scaled to Q1.15 with round half up
  function automatic sine_lut_t build_sine();
    sine_lut_t         lut;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   scaled;
    longint            sum;
    for (int i = 0; i <= int'(QUARTER_LEN); i++) begin
      x    = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (k)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          default: term = term / 64'd210;
        endcase
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > Q30_ONE) begin
        sum = Q30_ONE;
      end
      scaled = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (scaled > 64'd32767) begin
        scaled = 64'd32767;
      end
      lut[i] = LUT_W'(scaled);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

  function automatic coef_val_t sine_lookup(input logic [ANGLE_W-1:0] a);
    logic [SINE_TABLE_BITS:0] idx;
    coef_val_t                v;
    idx = {1'b0, a[ANGLE_W-3 -: SINE_TABLE_BITS]};
    if (a[ANGLE_W-2]) begin
      idx = (SINE_TABLE_BITS + 1)'(QUARTER_LEN) - idx;
    end
    v = {1'b0, SINE_LUT[idx]};
    return a[ANGLE_W-1] ? -v : v;
  endfunction

  function automatic coef_t coef_lookup(input logic [ANGLE_W-1:0] a);
    coef_t r;
    r.sin_v = sine_lookup(a);
    r.cos_v = sine_lookup(a + QUARTER_TURN);
    return r;
  endfunction

  localparam coef_t COEF_RESET = coef_lookup(ANGLE_RESET);

  // floor shift by FRAC_W, then clamp to the coordinate range
  function automatic coord_t shift_sat(input sum_t v);
    sum_t sh;
    sh = v >>> FRAC_W;
    if ((&sh[SUM_W-1:COORD_W-1]) || !(|sh[SUM_W-1:COORD_W-1])) begin
      return sh[COORD_W-1:0];
    end else if (sh[SUM_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

### src/erot_coef.sv
// APB register file for the three angles, plus the sine/cosine coefficients per axis.
// Depends on erot_pkg (table lookup and register map).
`timescale 1ns / 1ps
`default_nettype none

module erot_coef import erot_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output coef_t                   coef_x_o,
  output coef_t                   coef_y_o,
  output coef_t                   coef_z_o
);

  logic [ANGLE_W-1:0] angle_x_q, angle_y_q, angle_z_q;
  coef_t              coef_x_q, coef_y_q, coef_z_q;
  logic               wr_en;
  logic [ANGLE_W-1:0] wr_angle;
  coef_t              wr_coef;
  reg_idx_e           idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign wr_angle = pwdata[ANGLE_W-1:0];
  // coefficients are looked up at write time so they track the angle at once
  assign wr_coef  = coef_lookup(wr_angle);
  assign idx      = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= ANGLE_RESET;
      angle_y_q <= ANGLE_RESET;
      angle_z_q <= ANGLE_RESET;
      coef_x_q  <= COEF_RESET;
      coef_y_q  <= COEF_RESET;
      coef_z_q  <= COEF_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_ANGLE_X: begin
          angle_x_q <= wr_angle;
          coef_x_q  <= wr_coef;
        end
        REG_ANGLE_Y: begin
          angle_y_q <= wr_angle;
          coef_y_q  <= wr_coef;
        end
        REG_ANGLE_Z: begin
          angle_z_q <= wr_angle;
          coef_z_q  <= wr_coef;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ANGLE_X: prdata = PDATA_W'(angle_x_q);
      REG_ANGLE_Y: prdata = PDATA_W'(angle_y_q);
      REG_ANGLE_Z: prdata = PDATA_W'(angle_z_q);
      default:     prdata = '0;
    endcase
  end

  assign coef_x_o = coef_x_q;
  assign coef_y_o = coef_y_q;
  assign coef_z_o = coef_z_q;

endmodule

`default_nettype wire

### src/erot_step.sv
// One planar rotation: a' = c*a - s*b, b' = s*a + c*b, third coordinate carried along.
// Two register stages (products, then shift and saturate). Depends on erot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erot_step import erot_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire coef_t coef_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire coord_t a_i,
  input  wire coord_t b_i,
  input  wire coord_t p_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output coord_t     a_o,
  output coord_t     b_o,
  output coord_t     p_o
);

  logic   mv_q, sv_q;
  logic   en_m, en_s;
  prod_t  ca_q, sb_q, sa_q, cb_q;
  coord_t mp_q;
  coord_t a_q, b_q, p_q;
  sum_t   sum_a, sum_b;

  // a stage loads when it is empty or its contents move on
  assign en_s       = !sv_q || out_ready_i;
  assign en_m       = !mv_q || en_s;
  assign in_ready_o = en_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (en_m) begin
        mv_q <= in_valid_i;
      end
      if (en_s) begin
        sv_q <= mv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      ca_q <= prod_t'(coef_i.cos_v * a_i);
      sb_q <= prod_t'(coef_i.sin_v * b_i);
      sa_q <= prod_t'(coef_i.sin_v * a_i);
      cb_q <= prod_t'(coef_i.cos_v * b_i);
      mp_q <= p_i;
    end
  end

  assign sum_a = sum_t'(ca_q) - sum_t'(sb_q);
  assign sum_b = sum_t'(sa_q) + sum_t'(cb_q);

  always_ff @(posedge clk_i) begin
    if (en_s) begin
      a_q <= shift_sat(sum_a);
      b_q <= shift_sat(sum_b);
      p_q <= mp_q;
    end
  end

  assign out_valid_o = sv_q;
  assign a_o         = a_q;
  assign b_o         = b_q;
  assign p_o         = p_q;

endmodule

`default_nettype wire

### src/euler_point_rotator.sv
// Top level of the Euler point rotator: register file and three chained planar steps.
// Depends on erot_pkg, erot_coef and erot_step.
//
//  channel  | handshake                      | beat
//  ---------+--------------------------------+------------------------------
//  input    | in_valid_i / in_ready_o        | in_x_i, in_y_i, in_z_i
//  output   | out_valid_o / out_ready_i      | out_x_o, out_y_o, out_z_o
//  config   | APB psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One beat per cycle sustained while out_ready_i is high; two register stages per axis
// (product, then shift/saturate registers). The last stage is the output register.
// Each stage holds its own valid bit and loads whenever it is empty or draining,
// so bubbles close up during an output stall and no beat is dropped or repeated.
// Reset clears the valid bits and sets all three angles to 10430; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module euler_point_rotator import erot_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire coord_t             in_x_i,
  input  wire coord_t             in_y_i,
  input  wire coord_t             in_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output coord_t                  out_x_o,
  output coord_t                  out_y_o,
  output coord_t                  out_z_o
);

  coef_t  coef_x, coef_y, coef_z;
  logic   xv, xr, yv, yr;
  coord_t x_y, x_z, x_x;
  coord_t y_z, y_x, y_y;

  erot_coef u_coef (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .coef_x_o (coef_x),
    .coef_y_o (coef_y),
    .coef_z_o (coef_z)
  );

  // about X: (a, b) = (y, z)
  erot_step u_step_x (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_x),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .a_i         (in_y_i),
    .b_i         (in_z_i),
    .p_i         (in_x_i),
    .out_valid_o (xv),
    .out_ready_i (xr),
    .a_o         (x_y),
    .b_o         (x_z),
    .p_o         (x_x)
  );

  // about Y: (a, b) = (z, x)
  erot_step u_step_y (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_y),
    .in_valid_i  (xv),
    .in_ready_o  (xr),
    .a_i         (x_z),
    .b_i         (x_x),
    .p_i         (x_y),
    .out_valid_o (yv),
    .out_ready_i (yr),
    .a_o         (y_z),
    .b_o         (y_x),
    .p_o         (y_y)
  );

  // about Z: (a, b) = (x, y)
  erot_step u_step_z (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_z),
    .in_valid_i  (yv),
    .in_ready_o  (yr),
    .a_i         (y_x),
    .b_i         (y_y),
    .p_i         (y_z),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .a_o         (out_x_o),
    .b_o         (out_y_o),
    .p_o         (out_z_o)
  );

endmodule

`default_nettype wire

### verif/euler_point_rotator_tb.sv
// Self-checking testbench for euler_point_rotator: APB angle writes, point beats in, rotated
// beats out, compared against a fixed-point rotation predictor held in a small class.
// Depends on erot_pkg and the euler_point_rotator RTL.
`timescale 1ns / 1ps

module euler_point_rotator_tb import erot_pkg::*;;

  localparam int          LUT_BITS         = 10;
  localparam int          TABLE_LEN        = 1 << LUT_BITS;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint      Q30_UNITY        = 64'sd1 << 30;
  localparam coord_t      COORD_MAX        = {1'b0, {23{1'b1}}};
  localparam coord_t      COORD_MIN        = {1'b1, {23{1'b0}}};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 4'd12;
  localparam int          IDLE_MAX         = 14;
  localparam int          HOLD_CYCLES      = 250;
  localparam int          PIPE_DEPTH       = 10;
  localparam int          SETTLE_LIMIT     = 5000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  class rotation_ledger;
    logic [15:0] angle [3];
    longint      sine_q [0:TABLE_LEN];
    point_t      due_points [$];
    int          errors;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint          sum;
      longint          scaled;
      for (int i = 0; i <= TABLE_LEN; i++) begin
        x    = (longint'(i) * QUARTER_TURN_Q30) >> LUT_BITS;
        term = x;
        sum  = x;
        // Taylor series through x^15, Q30
        for (int k = 1; k <= 7; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) sum = 0;
        if (sum > Q30_UNITY) sum = Q30_UNITY;
        scaled = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        if (scaled > 32767) scaled = 32767;
        sine_q[i] = scaled;
      end
      for (int r = 0; r < 3; r++) angle[r] = 16'd10430;
      errors = 0;
    endfunction

    function void set_angle(int idx, logic [PDATA_W-1:0] v);
      if (idx < 3) angle[idx] = v[15:0];
    endfunction

    function longint sin_q15(logic [15:0] a);
      int unsigned i;
      longint      v;
      i = a[13:0] >> (14 - LUT_BITS);
      v = a[14] ? sine_q[TABLE_LEN - i] : sine_q[i];
      return a[15] ? -v : v;
    endfunction

    function longint cos_q15(logic [15:0] a);
      logic [15:0] b;
      b = a + 16'd16384;
      return sin_q15(b);
    endfunction

    function longint floor_sat(longint v);
      longint r;
      r = v >>> 15;
      if (r > longint'(COORD_MAX)) r = COORD_MAX;
      if (r < longint'(COORD_MIN)) r = COORD_MIN;
      return r;
    endfunction

    // each planar step reads only the pair that left the previous step
    function point_t rotate_point(point_t p);
      point_t r;
      longint x, y, z, t, c, s;
      x = $signed(p.x);
      y = $signed(p.y);
      z = $signed(p.z);
      c = cos_q15(angle[REG_ANGLE_X]);
      s = sin_q15(angle[REG_ANGLE_X]);
      t = floor_sat(c * y - s * z);
      z = floor_sat(s * y + c * z);
      y = t;
      c = cos_q15(angle[REG_ANGLE_Y]);
      s = sin_q15(angle[REG_ANGLE_Y]);
      t = floor_sat(c * x + s * z);
      z = floor_sat(c * z - s * x);
      x = t;
      c = cos_q15(angle[REG_ANGLE_Z]);
      s = sin_q15(angle[REG_ANGLE_Z]);
      t = floor_sat(c * x - s * y);
      y = floor_sat(s * x + c * y);
      x = t;
      r.x = coord_t'(x);
      r.y = coord_t'(y);
      r.z = coord_t'(z);
      return r;
    endfunction

    function void note_point(point_t p);
      due_points.push_back(rotate_point(p));
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (due_points.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d z=%0d", $time,
                 $signed(got.x), $signed(got.y), $signed(got.z));
        errors++;
        return;
      end
      want = due_points.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: out_x expected %0d got %0d", $time, $signed(want.x), $signed(got.x));
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y expected %0d got %0d", $time, $signed(want.y), $signed(got.y));
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: out_z expected %0d got %0d", $time, $signed(want.z), $signed(got.z));
        errors++;
      end
    endfunction

    function int pending();
      return due_points.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  coord_t             in_x_i;
  coord_t             in_y_i;
  coord_t             in_z_i;
  logic               out_valid_o;
  logic               out_ready_i;
  coord_t             out_x_o;
  coord_t             out_y_o;
  coord_t             out_z_o;

  rotation_ledger ledger;
  int             tx_max_gap   = IDLE_MAX;
  int             rx_max_stall = IDLE_MAX;
  bit             long_hold    = 1'b0;

  euler_point_rotator dut (.*);

  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      ledger.note_point(point_t'{in_x_i, in_y_i, in_z_i});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ledger.check_point(point_t'{out_x_o, out_y_o, out_z_o});
    end
  end

  // result side: random stalls per beat, one long hold on request
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        stall     = HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [PADDR_W-1:0] reg_addr(reg_idx_e r);
    return PADDR_W'({r, 2'b00});
  endfunction

  task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) ledger.set_angle(int'(addr) >> 2, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // psel drops and the bus idles between transfers
    @(posedge clk_i);
  endtask

  task automatic check_angle(input reg_idx_e r);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, reg_addr(r), '0, rd);
    if (rd[15:0] !== ledger.angle[r]) begin
      $display("%0t: %s readback expected %0d got %0d", $time, r.name(),
               ledger.angle[r], rd[15:0]);
      ledger.errors++;
    end
  endtask

  // upper data bits carry junk; only the low half should land
  task automatic write_angle(input reg_idx_e r, input logic [15:0] v);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, reg_addr(r), {16'($urandom), v}, rd);
    check_angle(r);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    for (int n = 0; n < SETTLE_LIMIT && ledger.pending() != 0; n++) @(posedge clk_i);
    repeat (PIPE_DEPTH) @(posedge clk_i);
  endtask

  task automatic set_angles(input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az);
    settle();
    write_angle(REG_ANGLE_X, ax);
    write_angle(REG_ANGLE_Y, ay);
    write_angle(REG_ANGLE_Z, az);
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i     <= x;
    in_y_i     <= y;
    in_z_i     <= z;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
      1: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'h4000;
        3: return 16'h8000;
        default: return 16'hC000;
      endcase
    end
    return 16'($urandom());
  endfunction

  initial begin
    logic [PDATA_W-1:0] rd;
    ledger     = new();
    rst_ni     <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid_i <= 1'b0;
    in_x_i     <= '0;
    in_y_i     <= '0;
    in_z_i     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset angles, untouched registers
    check_angle(REG_ANGLE_X);
    check_angle(REG_ANGLE_Y);
    check_angle(REG_ANGLE_Z);
    send_point('0, '0, '0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(coord_t'(1), '1, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX, '0);

    // 45 degrees on every axis drives the coordinates into saturation
    set_angles(16'h2000, 16'h2000, 16'h2000);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX);

    // write past the last register must leave the angles alone
    settle();
    apb_access(1'b1, ADDR_UNMAPPED, $urandom(), rd);
    check_angle(REG_ANGLE_X);
    check_angle(REG_ANGLE_Y);
    check_angle(REG_ANGLE_Z);
    send_point(coord_t'(4660), coord_t'(-22136), COORD_MAX);

    set_angles(16'h0000, 16'h0000, 16'h0000);
    send_point(COORD_MAX, COORD_MIN, coord_t'(12345));
    set_angles(16'h4000, 16'h8000, 16'hC000);
    send_point(COORD_MAX, COORD_MIN, coord_t'(1));
    send_point(COORD_MIN, '1, COORD_MAX);
    set_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(COORD_MAX, coord_t'(-77777), COORD_MIN);
    send_point(coord_t'(1), coord_t'(2), coord_t'(3));
    // table ends within a quadrant
    set_angles(16'h3FFF, 16'h7FF0, 16'hBFFF);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN);
    send_point(coord_t'(-500000), coord_t'(300000), coord_t'(8));

    for (int ph = 0; ph < 8; ph++) begin
      set_angles(pick_angle(), pick_angle(), pick_angle());
      tx_max_gap   = (ph == 2 || ph == 4) ? 0 : IDLE_MAX;
      rx_max_stall = (ph == 2 || ph == 5) ? 0 : IDLE_MAX;
      long_hold    = (ph == 4);
      for (int n = 0; n < 119; n++) begin
        send_point(random_coord(), random_coord(), random_coord());
      end
    end

    settle();
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/erot_pkg.sv
src/erot_coef.sv
src/erot_step.sv
src/euler_point_rotator.sv
verif/euler_point_rotator_tb.sv
